@@ rtl/dst_pkg.sv @@
// Shared types and constants for the dependency string tokenizer.
`timescale 1ns / 1ps

package dst_pkg;

  localparam int unsigned MAX_LEN_DEF = 4096;
  localparam int unsigned TOK_W       = 12;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_START_IN   = 3'd0,
    ST_ACCUM_IN   = 3'd1,
    ST_START_OUT  = 3'd2,
    ST_ACCUM_OUT  = 3'd3,
    ST_START_CHAR = 3'd4,
    ST_ACCUM_CHAR = 3'd5
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_IN   = 2'd0,
    KIND_OUT  = 2'd1,
    KIND_CHAR = 2'd2,
    KIND_DONE = 2'd3
  } token_kind_e;

  // One record per byte that produces results. With two set, the word is
  // followed by a done token at position tok_end.
  typedef struct packed {
    logic              two;
    token_kind_e       kind;
    logic [TOK_W-1:0]  tok_start;
    logic [TOK_W-1:0]  tok_end;
  } rec_t;

endpackage

@@ rtl/dst_front.sv @@
// Parse automaton: classifies each byte and builds its result record.
`timescale 1ns / 1ps

module dst_front import dst_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              start_of_string_i,
  output logic              rec_valid_o,
  output rec_t              rec_o
);

  localparam int unsigned POS_W = $clog2(MAX_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEN - 1);

  parse_state_e     state_q, state_d;
  logic             esc_q, esc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] wb_q, wb_d;
  logic             fin_q, fin_d;

  parse_state_e     st_e, st_b;
  logic             esc_e, fin_e;
  logic [POS_W-1:0] pos_e, wb_e;
  logic             word, done, adv;
  token_kind_e      wkind;
  logic             is_space, is_gt, is_semi, is_nul, is_bsl;

  assign is_space = (data_byte_i == CH_SPACE);
  assign is_gt    = (data_byte_i == CH_GT);
  assign is_semi  = (data_byte_i == CH_SEMI);
  assign is_nul   = (data_byte_i == CH_NUL);
  assign is_bsl   = (data_byte_i == CH_BSL);

  always_comb begin
    // A start flag rearms the parser before this byte is looked at.
    st_e  = start_of_string_i ? ST_START_IN : state_q;
    esc_e = start_of_string_i ? 1'b0 : esc_q;
    fin_e = start_of_string_i ? 1'b0 : fin_q;
    pos_e = start_of_string_i ? '0 : pos_q;
    wb_e  = start_of_string_i ? '0 : wb_q;

    word    = 1'b0;
    done    = 1'b0;
    adv     = 1'b0;
    wkind   = KIND_IN;
    st_b    = st_e;
    state_d = st_e;
    esc_d   = 1'b0;
    wb_d    = wb_e;
    fin_d   = fin_e;

    if (fin_e) begin
      esc_d = esc_e;
    end else if (esc_e && !is_nul) begin
      adv = 1'b1;
    end else begin
      // First pass: close an open word on its delimiter.
      case (st_e)
        ST_ACCUM_IN, ST_ACCUM_OUT: begin
          if (is_space || is_gt || is_semi || is_nul) begin
            word  = 1'b1;
            wkind = (st_e == ST_ACCUM_OUT) ? KIND_OUT : KIND_IN;
            if (is_space) begin
              st_b = (st_e == ST_ACCUM_OUT) ? ST_START_CHAR : ST_START_IN;
            end else if (is_gt) begin
              st_b = ST_START_OUT;
            end else begin
              st_b = ST_START_IN;
            end
          end
        end
        ST_ACCUM_CHAR: begin
          if (is_gt || is_semi || is_nul) begin
            word  = 1'b1;
            wkind = KIND_CHAR;
            st_b  = is_gt ? ST_START_OUT : ST_START_IN;
          end
        end
        ST_START_OUT, ST_START_CHAR: st_b = st_e;
        default: st_b = ST_START_IN;
      endcase

      // Second pass: rescan the byte in the (possibly new) state.
      case (st_b)
        ST_ACCUM_IN, ST_ACCUM_OUT, ST_ACCUM_CHAR: begin
          adv     = 1'b1;
          state_d = st_b;
          esc_d   = (st_b == ST_ACCUM_CHAR) && is_bsl;
        end
        default: begin
          if (is_space) begin
            adv     = 1'b1;
            state_d = st_b;
          end else if (is_gt) begin
            adv     = 1'b1;
            state_d = ST_START_OUT;
          end else if (is_semi) begin
            adv     = 1'b1;
            state_d = ST_START_IN;
          end else if (is_nul) begin
            done    = 1'b1;
            state_d = ST_START_IN;
            fin_d   = 1'b1;
          end else begin
            adv  = 1'b1;
            wb_d = pos_e;
            if (st_b == ST_START_OUT) begin
              state_d = ST_ACCUM_OUT;
            end else if (st_b == ST_START_CHAR) begin
              state_d = ST_ACCUM_CHAR;
              esc_d   = is_bsl;
            end else begin
              state_d = ST_ACCUM_IN;
            end
          end
        end
      endcase
    end

    // Saturate at the last position.
    pos_d = (adv && (pos_e != POS_LAST)) ? pos_e + POS_W'(1) : pos_e;

    rec_valid_o   = word || done;
    rec_o.two     = word && done;
    rec_o.kind    = word ? wkind : KIND_DONE;
    rec_o.tok_start = word ? TOK_W'(wb_e) : TOK_W'(pos_e);
    rec_o.tok_end   = TOK_W'(pos_e);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START_IN;
      esc_q   <= 1'b0;
      pos_q   <= '0;
      wb_q    <= '0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      state_q <= state_d;
      esc_q   <= esc_d;
      pos_q   <= pos_d;
      wb_q    <= wb_d;
      fin_q   <= fin_d;
    end
  end

endmodule

@@ rtl/dst_queue.sv @@
// Short record queue between the parser and the output stage.
`timescale 1ns / 1ps

module dst_queue import dst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t pop_rec_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  rec_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == CNT_FULL);
  assign valid_o   = (cnt_q != '0);
  assign pop_rec_o = entry_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1)) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1)) : rd_q;
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_rec_i;
    end
  end

endmodule

@@ rtl/dst_back.sv @@
// Output stage: holds one record and sends its one or two tokens.
`timescale 1ns / 1ps

module dst_back import dst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  rec_t             q_rec_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output token_kind_e      kind_o,
  output logic [TOK_W-1:0] tok_start_o,
  output logic [TOK_W-1:0] tok_end_o,
  output logic             last_o
);

  rec_t rec_q;
  logic valid_q, valid_d;
  logic second_q, second_d;
  logic final_tok, take;

  // The token on the port is the final one of its record.
  assign final_tok = !rec_q.two || second_q;
  assign take      = !valid_q || (ready_i && final_tok);
  assign pop_o     = take && q_valid_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    if (take) begin
      valid_d  = q_valid_i;
      second_d = 1'b0;
    end else if (ready_i) begin
      second_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= q_rec_i;
    end
  end

  assign valid_o     = valid_q;
  assign kind_o      = second_q ? KIND_DONE : rec_q.kind;
  assign tok_start_o = second_q ? rec_q.tok_end : rec_q.tok_start;
  assign tok_end_o   = rec_q.tok_end;
  assign last_o      = final_tok;

endmodule

@@ rtl/dependency_string_tokenizer.sv @@
// Top level of the dependency string tokenizer.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream s_axis: one byte of a dependency string per transaction.
//   tdata carries the byte, tuser[0] marks the first byte of a new string.
//   A NUL byte ends the string; later bytes are dropped without a token
//   until the next start flag. Without a start flag after reset the parser
//   is already armed.
//   Master stream m_axis: one token per transaction. tdata carries the
//   start and end byte positions, tuser the token kind (input word, output
//   word, characterization string, done), tlast marks the final token
//   caused by a byte.
// Timing:
//   One byte is taken every cycle while the queue has room. A token passes
//   through the queue and the output stage register; a byte that closes a
//   word and ends the string gives two tokens and holds the output stage
//   until both are taken. The parser and the output stage are parted by a
//   two-record queue, so s_axis_tready falls only when that queue is full.
// Reset:
//   rst_ni clears the parser, the queue and the output valid at once.
//
module dependency_string_tokenizer import dst_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] start_of_string
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [2*TOK_W-1:0]     m_axis_tdata,   // [11:0] token_start, [23:12] token_end
  output logic [1:0]             m_axis_tuser,   // [1:0] token_kind
  output logic                   m_axis_tlast    // last_result
);

  logic             accept;
  logic             rec_valid, q_full, q_valid, pop;
  rec_t             rec, q_rec;
  token_kind_e      kind;
  logic [TOK_W-1:0] tok_start, tok_end;

  // Accept a byte whenever the queue has room for its record.
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dst_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (s_axis_tdata),
    .start_of_string_i (s_axis_tuser),
    .rec_valid_o       (rec_valid),
    .rec_o             (rec)
  );

  dst_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && rec_valid),
    .push_rec_i (rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_rec_o  (q_rec)
  );

  dst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rec),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .kind_o      (kind),
    .tok_start_o (tok_start),
    .tok_end_o   (tok_end),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {tok_end, tok_start};
  assign m_axis_tuser = kind;

endmodule
